// ===== rtl/gicu_pkg.sv =====
// Shared constants and types for the growth interface column update block.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package gicu_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_BOUNDARY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ENABLED = 2'd1;

    typedef struct packed {
        logic fixed_boundary;
        logic center_enabled;
    } cfg_t;

    // what the update stage hands to the result serializer
    typedef struct packed {
        logic has_main;   // chosen column produced a word (pixel or finished)
        logic main_on;    // set or clear for that pixel
        logic fin;        // full height reached
        logic edges;      // set and clear words for both outer columns follow
    } bundle_flags_t;

endpackage

`default_nettype wire

// ===== rtl/gicu_in_if.sv =====
// Input item channel: valid/ready plus the column update request.
// Depends on nothing; widths follow GRID_SIZE.
`default_nettype none

interface gicu_in_if #(parameter int GRID_SIZE = 512) ();
    localparam int CW = $clog2(GRID_SIZE);

    logic          valid;
    logic          ready;
    logic [CW-1:0] column;
    logic          shrink_try;
    logic          spont_grow;
    logic          center_grow;

    modport source (output valid, output column, output shrink_try, output spont_grow,
                    output center_grow, input ready);
    modport sink   (input valid, input column, input shrink_try, input spont_grow,
                    input center_grow, output ready);
endinterface

`default_nettype wire

// ===== rtl/gicu_out_if.sv =====
// Result channel: valid/ready plus one changed pixel per word.
// Depends on nothing; widths follow GRID_SIZE.
`default_nettype none

interface gicu_out_if #(parameter int GRID_SIZE = 512) ();
    localparam int CW = $clog2(GRID_SIZE);
    localparam int HW = $clog2(GRID_SIZE + 1);

    logic          valid;
    logic          ready;
    logic [CW-1:0] pixel_col;
    logic [HW-1:0] pixel_row;
    logic          pixel_on;
    logic          finished;
    logic          last;

    modport source (output valid, output pixel_col, output pixel_row, output pixel_on,
                    output finished, output last, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input pixel_on,
                    input finished, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/gicu_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on gicu_pkg for the field widths.
`default_nettype none

interface gicu_cfg_if ();
    logic                             valid;
    logic                             ready;
    logic [gicu_pkg::CFG_IDX_W-1:0]   index;
    logic [gicu_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gicu_ram.sv =====
// Column height store: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module gicu_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output      logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/gicu_update.sv =====
// Column update decision: neighbor compare, new height, edge copy values.
// Depends on gicu_pkg (cfg_t, bundle_flags_t).
`default_nettype none

module gicu_update #(
    parameter  int GRID_SIZE = 512,
    localparam int CW        = $clog2(GRID_SIZE),
    localparam int HW        = $clog2(GRID_SIZE + 1)
) (
    input  wire logic [CW-1:0]           col,
    input  wire logic                    shrink_try,
    input  wire logic                    spont_grow,
    input  wire logic                    center_grow,
    input  wire gicu_pkg::cfg_t          cfg,
    input  wire logic                    halted,
    input  wire logic [HW-1:0]           ram_l,
    input  wire logic [HW-1:0]           ram_c,
    input  wire logic [HW-1:0]           ram_r,
    input  wire logic                    byp_valid,
    input  wire logic [CW-1:0]           byp_addr,
    input  wire logic [HW-1:0]           byp_h,
    input  wire logic [HW-1:0]           e0,
    input  wire logic [HW-1:0]           h1,
    input  wire logic [HW-1:0]           hn2,
    input  wire logic [HW-1:0]           en,
    output      logic                    wr_en,
    output      logic [HW-1:0]           nh,
    output      logic                    halt_set,
    output      logic [HW-1:0]           e0_new,
    output      logic [HW-1:0]           h1_new,
    output      logic [HW-1:0]           hn2_new,
    output      logic [HW-1:0]           en_new,
    output      gicu_pkg::bundle_flags_t flags,
    output      logic [HW-1:0]           main_row,
    output      logic                    load
);

    localparam logic [CW-1:0] COL_FIRST = CW'(1);
    localparam logic [CW-1:0] COL_LAST  = CW'(GRID_SIZE - 2);
    localparam logic [CW-1:0] COL_MID   = CW'(GRID_SIZE / 2);
    localparam logic [HW-1:0] FULL      = HW'(GRID_SIZE);

    logic [CW-1:0] xl;
    logic [CW-1:0] xr;
    logic [HW-1:0] hl;
    logic [HW-1:0] hc;
    logic [HW-1:0] hr;
    logic [HW-1:0] hc_inc;
    logic          act;
    logic          grow;
    logic          shr;
    logic          fin;
    logic          edges;

    assign xl = col - CW'(1);
    assign xr = col + CW'(1);

    // the outer columns live in registers; interior reads take the last write
    // when it landed on the same edge as the read
    assign hl = (col == COL_FIRST) ? e0 :
                ((byp_valid && (byp_addr == xl)) ? byp_h : ram_l);
    assign hc = (byp_valid && (byp_addr == col)) ? byp_h : ram_c;
    assign hr = (col == COL_LAST) ? en :
                ((byp_valid && (byp_addr == xr)) ? byp_h : ram_r);

    assign hc_inc = hc + HW'(1);

    assign act  = (col >= COL_FIRST) && (col <= COL_LAST) && !halted;
    assign grow = act && !shrink_try &&
                  ((hl > hc) || (hr > hc) || spont_grow ||
                   (cfg.center_enabled && (col == COL_MID) && center_grow));
    assign shr  = act && shrink_try && ((hl < hc) || (hr < hc));
    assign fin  = grow && (hc_inc == FULL);

    always_comb
    begin
        if (grow)
        begin
            nh = hc_inc;
        end
        else if (shr)
        begin
            nh = hc - HW'(1);
        end
        else
        begin
            nh = hc;
        end
    end

    assign wr_en    = act;
    assign halt_set = fin;
    assign edges    = act && !fin && cfg.fixed_boundary;

    assign h1_new  = (act && (col == COL_FIRST)) ? nh : h1;
    assign hn2_new = (act && (col == COL_LAST))  ? nh : hn2;
    assign e0_new  = edges ? h1_new  : e0;
    assign en_new  = edges ? hn2_new : en;

    // shrink clears the old top row, grow sets the new one
    assign main_row = shr ? hc : nh;

    assign flags.has_main = grow || shr;
    assign flags.main_on  = grow && !fin;
    assign flags.fin      = fin;
    assign flags.edges    = edges;
    assign load           = grow || shr || edges;

endmodule

`default_nettype wire

// ===== rtl/gicu_emit.sv =====
// Result serializer: holds one item's words and hands them out in order.
// Depends on gicu_pkg (bundle_flags_t) and gicu_out_if.
`default_nettype none

module gicu_emit #(
    parameter  int GRID_SIZE = 512,
    localparam int CW        = $clog2(GRID_SIZE),
    localparam int HW        = $clog2(GRID_SIZE + 1)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire gicu_pkg::bundle_flags_t flags,
    input  wire logic [CW-1:0]           col,
    input  wire logic [HW-1:0]           main_row,
    input  wire logic [HW-1:0]           el,
    input  wire logic [HW-1:0]           er,
    output      logic                    free,
    gicu_out_if.source                   pixel
);

    localparam logic [2:0] SLOT_MAIN  = 3'd0;
    localparam logic [2:0] SLOT_L_SET = 3'd1;
    localparam logic [2:0] SLOT_L_CLR = 3'd2;
    localparam logic [2:0] SLOT_R_SET = 3'd3;
    localparam logic [2:0] SLOT_R_CLR = 3'd4;

    localparam logic [CW-1:0] COL_RIGHT = CW'(GRID_SIZE - 1);

    logic                    valid_reg;
    logic                    valid_next;
    logic [2:0]              slot_reg;
    logic [2:0]              slot_next;
    logic [2:0]              slot_succ;
    gicu_pkg::bundle_flags_t flags_reg;
    logic [CW-1:0]           col_reg;
    logic [HW-1:0]           row_reg;
    logic [HW-1:0]           el_reg;
    logic [HW-1:0]           er_reg;
    logic                    fire;
    logic                    word_last;

    always_comb
    begin
        pixel.pixel_col = '0;
        pixel.pixel_row = '0;
        pixel.pixel_on  = 1'b0;
        pixel.finished  = 1'b0;
        word_last       = 1'b1;
        slot_succ       = SLOT_MAIN;
        case (slot_reg)
            SLOT_MAIN:
            begin
                pixel.pixel_col = col_reg;
                pixel.pixel_row = row_reg;
                pixel.pixel_on  = flags_reg.main_on;
                pixel.finished  = flags_reg.fin;
                word_last       = !flags_reg.edges;
                slot_succ       = SLOT_L_SET;
            end
            SLOT_L_SET:
            begin
                pixel.pixel_row = el_reg;
                pixel.pixel_on  = 1'b1;
                word_last       = 1'b0;
                slot_succ       = SLOT_L_CLR;
            end
            SLOT_L_CLR:
            begin
                pixel.pixel_row = el_reg + HW'(1);
                word_last       = 1'b0;
                slot_succ       = SLOT_R_SET;
            end
            SLOT_R_SET:
            begin
                pixel.pixel_col = COL_RIGHT;
                pixel.pixel_row = er_reg;
                pixel.pixel_on  = 1'b1;
                word_last       = 1'b0;
                slot_succ       = SLOT_R_CLR;
            end
            SLOT_R_CLR:
            begin
                pixel.pixel_col = COL_RIGHT;
                pixel.pixel_row = er_reg + HW'(1);
            end
            default:
            begin
                word_last = 1'b1;
            end
        endcase
    end

    assign pixel.valid = valid_reg;
    assign pixel.last  = word_last;
    assign fire        = valid_reg && pixel.ready;
    assign free        = !valid_reg || (fire && word_last);

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        if (load)
        begin
            valid_next = 1'b1;
            slot_next  = flags.has_main ? SLOT_MAIN : SLOT_L_SET;
        end
        else if (fire && word_last)
        begin
            valid_next = 1'b0;
        end
        else if (fire)
        begin
            slot_next = slot_succ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= SLOT_MAIN;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= flags;
            col_reg   <= col;
            row_reg   <= main_row;
            el_reg    <= el;
            er_reg    <= er;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/growth_interface_column_update.sv =====
// Top level of the growth interface column update block.
// Depends on gicu_pkg, the three channel interfaces, gicu_ram, gicu_update, gicu_emit.
//
//   port    dir  carries
//   ------  ---  ------------------------------------------------------------
//   item    in   column, shrink_try, spont_grow, center_grow
//   pixel   out  pixel_col, pixel_row, pixel_on, finished, last
//   cfg     in   index, data  (0 fixed_boundary, 1 center_enabled)
//
// An item's heights are read from the height store as it is accepted, the
// update stage decides, then its words leave one per cycle while pixel.ready
// is high: 0, 1, 4 or 5 words per item. An item with words holds the result
// register until its last word is taken; the next item waits in the update
// stage meanwhile. After reset the height store is cleared one column a cycle,
// all GRID_SIZE columns, with item.ready low; cfg writes are taken throughout.
`default_nettype none

module growth_interface_column_update #(
    parameter int GRID_SIZE = 512
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gicu_in_if.sink   item,
    gicu_out_if.source pixel,
    gicu_cfg_if.sink  cfg
);

    localparam int CW = $clog2(GRID_SIZE);
    localparam int HW = $clog2(GRID_SIZE + 1);

    localparam logic [CW-1:0] CLR_END = CW'(GRID_SIZE - 1);

    gicu_pkg::cfg_t cfg_reg;

    logic          clr_busy_reg;
    logic [CW-1:0] clr_addr_reg;

    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_shrink_reg;
    logic          s1_spont_reg;
    logic          s1_center_reg;

    logic          byp_valid_reg;
    logic [CW-1:0] byp_addr_reg;
    logic [HW-1:0] byp_h_reg;

    logic          halted_reg;
    logic [HW-1:0] e0_reg;
    logic [HW-1:0] h1_reg;
    logic [HW-1:0] hn2_reg;
    logic [HW-1:0] en_reg;

    logic          accept;
    logic          s1_adv;
    logic          emit_free;

    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [HW-1:0] ram_wdata;
    logic [HW-1:0] ram_l;
    logic [HW-1:0] ram_c;
    logic [HW-1:0] ram_r;

    logic                    upd_wr_en;
    logic [HW-1:0]           upd_nh;
    logic                    upd_halt_set;
    logic [HW-1:0]           upd_e0;
    logic [HW-1:0]           upd_h1;
    logic [HW-1:0]           upd_hn2;
    logic [HW-1:0]           upd_en;
    gicu_pkg::bundle_flags_t upd_flags;
    logic [HW-1:0]           upd_row;
    logic                    upd_load;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                gicu_pkg::CFG_FIXED_BOUNDARY: cfg_reg.fixed_boundary <= cfg.data[0];
                gicu_pkg::CFG_CENTER_ENABLED: cfg_reg.center_enabled <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // height store clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + CW'(1);
            if (clr_addr_reg == CLR_END)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign s1_adv     = s1_valid_reg && emit_free;
    assign item.ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign accept     = item.valid && item.ready;

    assign ram_we    = clr_busy_reg || (s1_adv && upd_wr_en);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s1_col_reg;
    assign ram_wdata = clr_busy_reg ? '0 : upd_nh;

    gicu_ram #(.DEPTH(GRID_SIZE), .AW(CW), .DW(HW)) u_ram_l (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (item.column - CW'(1)),
        .rdata (ram_l)
    );

    gicu_ram #(.DEPTH(GRID_SIZE), .AW(CW), .DW(HW)) u_ram_c (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (item.column),
        .rdata (ram_c)
    );

    gicu_ram #(.DEPTH(GRID_SIZE), .AW(CW), .DW(HW)) u_ram_r (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (item.column + CW'(1)),
        .rdata (ram_r)
    );

    // update stage input register; hold while the serializer is busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg  <= 1'b1;
            byp_valid_reg <= ram_we;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg    <= item.column;
            s1_shrink_reg <= item.shrink_try;
            s1_spont_reg  <= item.spont_grow;
            s1_center_reg <= item.center_grow;
            byp_addr_reg  <= ram_waddr;
            byp_h_reg     <= ram_wdata;
        end
    end

    // outer columns and halt flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg <= 1'b0;
            e0_reg     <= '0;
            h1_reg     <= '0;
            hn2_reg    <= '0;
            en_reg     <= '0;
        end
        else if (s1_adv)
        begin
            halted_reg <= halted_reg || upd_halt_set;
            e0_reg     <= upd_e0;
            h1_reg     <= upd_h1;
            hn2_reg    <= upd_hn2;
            en_reg     <= upd_en;
        end
    end

    gicu_update #(.GRID_SIZE(GRID_SIZE)) u_update (
        .col         (s1_col_reg),
        .shrink_try  (s1_shrink_reg),
        .spont_grow  (s1_spont_reg),
        .center_grow (s1_center_reg),
        .cfg         (cfg_reg),
        .halted      (halted_reg),
        .ram_l       (ram_l),
        .ram_c       (ram_c),
        .ram_r       (ram_r),
        .byp_valid   (byp_valid_reg),
        .byp_addr    (byp_addr_reg),
        .byp_h       (byp_h_reg),
        .e0          (e0_reg),
        .h1          (h1_reg),
        .hn2         (hn2_reg),
        .en          (en_reg),
        .wr_en       (upd_wr_en),
        .nh          (upd_nh),
        .halt_set    (upd_halt_set),
        .e0_new      (upd_e0),
        .h1_new      (upd_h1),
        .hn2_new     (upd_hn2),
        .en_new      (upd_en),
        .flags       (upd_flags),
        .main_row    (upd_row),
        .load        (upd_load)
    );

    gicu_emit #(.GRID_SIZE(GRID_SIZE)) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_adv && upd_load),
        .flags    (upd_flags),
        .col      (s1_col_reg),
        .main_row (upd_row),
        .el       (upd_e0),
        .er       (upd_en),
        .free     (emit_free),
        .pixel    (pixel)
    );

endmodule

`default_nettype wire

// ===== rtl/gicu_chk.sv =====
// Port-level checker for the growth interface column update block.
// Depends on nothing but the top level's ports; bound to the top level below.
`default_nettype none

module gicu_chk #(
    parameter  int GRID_SIZE = 512,
    localparam int CW        = $clog2(GRID_SIZE),
    localparam int HW        = $clog2(GRID_SIZE + 1)
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          pixel_valid,
    input wire logic          pixel_ready,
    input wire logic [CW-1:0] pixel_col,
    input wire logic [HW-1:0] pixel_row,
    input wire logic          pixel_on,
    input wire logic          finished,
    input wire logic          last
);

    logic fin_seen_reg;

    // remember that the finished word went out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_seen_reg <= 1'b0;
        end
        else if (pixel_valid && pixel_ready && finished)
        begin
            fin_seen_reg <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=>
            pixel_valid && $stable({pixel_col, pixel_row, pixel_on, finished, last}))
        else $error("result word changed while stalled");

    a_fin_word: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && finished |->
            last && !pixel_on && (pixel_row == HW'(GRID_SIZE)))
        else $error("finished word malformed");

    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fin_seen_reg |-> !pixel_valid)
        else $error("result after halt");

    a_edge_pair: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && (pixel_col == '0) && pixel_on |=>
            pixel_valid && (pixel_col == '0) && !pixel_on &&
            (pixel_row == $past(pixel_row) + HW'(1)))
        else $error("left edge set not followed by its clear");

endmodule

bind growth_interface_column_update gicu_chk #(.GRID_SIZE(GRID_SIZE)) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .pixel_col   (pixel.pixel_col),
    .pixel_row   (pixel.pixel_row),
    .pixel_on    (pixel.pixel_on),
    .finished    (pixel.finished),
    .last        (pixel.last)
);

`default_nettype wire

// ===== test/gicu_checker.sv =====
// Scoreboard for the growth interface column update block: tracks column heights,
// predicts the pixel words of each accepted item and compares them in order.
// Depends on gicu_pkg and the three channel interfaces.
`timescale 1ns / 100ps

module gicu_checker #(
    parameter int GRID_SIZE = 512
) (
    input  logic clk,
    input  logic rst_n,
    gicu_in_if   item,
    gicu_out_if  pixel,
    gicu_cfg_if  cfg,
    output int   mismatches,
    output int   backlog
);

    localparam int CW = $clog2(GRID_SIZE);
    localparam int HW = $clog2(GRID_SIZE + 1);

    typedef struct packed {
        logic [CW-1:0] col;
        logic [HW-1:0] row;
        logic          on;
        logic          fin;
        logic          last;
    } pixel_word_t;

    int unsigned heights [GRID_SIZE];
    bit          frozen;
    bit          edge_copy;
    bit          center_on;
    pixel_word_t pixel_expect [$];

    function automatic pixel_word_t pixel_word(int unsigned col, int unsigned row,
                                               bit on, bit fin);
        pixel_word_t w;
        w.col  = col[CW-1:0];
        w.row  = row[HW-1:0];
        w.on   = on;
        w.fin  = fin;
        w.last = 1'b0;
        return w;
    endfunction

    function automatic string show(pixel_word_t w);
        return $sformatf("col=%0d row=%0d on=%0b fin=%0b last=%0b",
                         w.col, w.row, w.on, w.fin, w.last);
    endfunction

    // Apply one column update to the height map and queue the words it causes.
    task automatic step_column(input logic [CW-1:0] column, input logic shrink,
                               input logic spont, input logic center);
        int unsigned x, h, nh, e;
        pixel_word_t burst [$];
        pixel_word_t w;
        if (frozen || column < 1 || column > GRID_SIZE - 2)
            return;
        x  = 32'(column);
        h  = heights[x];
        nh = h;
        if (!shrink)
        begin
            if (heights[x-1] > h || heights[x+1] > h || spont ||
                (center_on && x == GRID_SIZE / 2 && center))
                nh = h + 1;
        end
        else if (heights[x-1] < h || heights[x+1] < h)
            nh = h - 1;
        heights[x] = nh;

        if (nh >= GRID_SIZE)
        begin
            frozen = 1'b1;
            burst.push_back(pixel_word(x, nh, 1'b0, 1'b1));
        end
        else
        begin
            if (nh < h)
                burst.push_back(pixel_word(x, h, 1'b0, 1'b0));
            if (nh > h)
                burst.push_back(pixel_word(x, h + 1, 1'b1, 1'b0));
            if (edge_copy)
            begin
                heights[0] = heights[1];
                e = heights[0];
                burst.push_back(pixel_word(0, e, 1'b1, 1'b0));
                burst.push_back(pixel_word(0, e + 1, 1'b0, 1'b0));
                heights[GRID_SIZE-1] = heights[GRID_SIZE-2];
                e = heights[GRID_SIZE-1];
                burst.push_back(pixel_word(GRID_SIZE - 1, e, 1'b1, 1'b0));
                burst.push_back(pixel_word(GRID_SIZE - 1, e + 1, 1'b0, 1'b0));
            end
        end
        foreach (burst[i])
        begin
            w = burst[i];
            w.last = (i == burst.size() - 1);
            pixel_expect.push_back(w);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_word_t got, want;
        if (!rst_n)
        begin
            foreach (heights[i])
                heights[i] = 0;
            frozen     = 1'b0;
            edge_copy  = 1'b0;
            center_on  = 1'b0;
            pixel_expect.delete();
            mismatches = 0;
        end
        else
        begin
            if (pixel.valid && pixel.ready)
            begin
                got.col  = pixel.pixel_col;
                got.row  = pixel.pixel_row;
                got.on   = pixel.pixel_on;
                got.fin  = pixel.finished;
                got.last = pixel.last;
                if (pixel_expect.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected pixel word %s", $time, show(got));
                end
                else
                begin
                    want = pixel_expect.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: pixel word mismatch, expected %s, got %s",
                                 $time, show(want), show(got));
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    gicu_pkg::CFG_FIXED_BOUNDARY: edge_copy = cfg.data[0];
                    gicu_pkg::CFG_CENTER_ENABLED: center_on = cfg.data[0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                step_column(item.column, item.shrink_try, item.spont_grow, item.center_grow);
        end
        backlog = pixel_expect.size();
    end

endmodule

// ===== test/tb_growth_interface_column_update.sv =====
// Testbench top for growth_interface_column_update: clock, reset, item and
// config stimulus, pixel back-pressure and the verdict. Checking is in gicu_checker.
// Depends on gicu_pkg, the channel interfaces, the block and gicu_checker.
`timescale 1ns / 100ps

module tb_growth_interface_column_update;

    localparam int GRID = 512;
    localparam int CW   = $clog2(GRID);
    localparam int SQUEEZE_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 16;

    localparam logic [gicu_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [gicu_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   backlog;
    bit   no_gaps;
    bit   squeeze_req;

    gicu_in_if  #(.GRID_SIZE(GRID)) item_ch ();
    gicu_out_if #(.GRID_SIZE(GRID)) pixel_ch ();
    gicu_cfg_if                     cfg_ch ();

    growth_interface_column_update #(.GRID_SIZE(GRID)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .pixel (pixel_ch),
        .cfg   (cfg_ch)
    );

    gicu_checker #(.GRID_SIZE(GRID)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .pixel      (pixel_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("[growth_interface_column_update] ERROR");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Bias columns toward the edges and the middle so heights build up.
    function automatic logic [CW-1:0] pick_column();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return CW'($urandom_range(1, 6));
        if (r < 65)
            return CW'($urandom_range(GRID / 2 - 4, GRID / 2 + 4));
        if (r < 85)
            return CW'($urandom_range(GRID - 7, GRID - 2));
        if (r < 95)
            return CW'($urandom_range(1, GRID - 2));
        return $urandom_range(0, 1) ? CW'(GRID - 1) : CW'(0);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_column(input logic [CW-1:0] column, input logic shrink,
                               input logic spont, input logic center);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.column      <= column;
        item_ch.shrink_try  <= shrink;
        item_ch.spont_grow  <= spont;
        item_ch.center_grow <= center;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [gicu_pkg::CFG_IDX_W-1:0] index, input logic value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, wait for every pixel word, then let the pipeline empty.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (backlog != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input logic edge_copy, input logic center_on);
        settle();
        write_reg(gicu_pkg::CFG_FIXED_BOUNDARY, edge_copy);
        write_reg(gicu_pkg::CFG_CENTER_ENABLED, center_on);
    endtask

    task automatic random_phase(input int count);
        logic [CW-1:0] col;
        int done;
        done = 0;
        while (done < count)
        begin
            col = pick_column();
            if (col >= 1 && col <= GRID - 2)
                done++;
            send_column(col, $urandom_range(0, 99) < 40, $urandom_range(0, 99) < 30,
                        1'($urandom_range(0, 1)));
        end
    endtask

    // pixel sink: random stalls, plus one long hold-off on request
    initial
    begin : pixel_sink
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                pixel_ch.ready <= 1'b0;
                hold--;
            end
            else if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                pixel_ch.ready <= 1'b0;
                hold = SQUEEZE_CYCLES - 1;
            end
            else
            begin
                hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                pixel_ch.ready <= (hold == 0);
                if (hold > 0)
                    hold--;
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        no_gaps             = 1'b0;
        squeeze_req         = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.column      = '0;
        item_ch.shrink_try  = 1'b0;
        item_ch.spont_grow  = 1'b0;
        item_ch.center_grow = 1'b0;
        pixel_ch.ready      = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unused indexes must not disturb anything
        write_reg(CFG_SPARE_LO, 1'b1);
        write_reg(CFG_SPARE_HI, 1'b1);
        write_reg(gicu_pkg::CFG_FIXED_BOUNDARY, 1'b0);
        write_reg(gicu_pkg::CFG_CENTER_ENABLED, 1'b0);

        // out of range columns, edges of the interior, neighbor-driven moves
        send_column(CW'(0), 1'b0, 1'b1, 1'b1);
        send_column(CW'(GRID - 1), 1'b0, 1'b1, 1'b1);
        send_column(CW'(1), 1'b0, 1'b1, 1'b0);
        send_column(CW'(GRID - 2), 1'b0, 1'b1, 1'b0);
        send_column(CW'(GRID / 2), 1'b0, 1'b0, 1'b1);
        send_column(CW'(2), 1'b0, 1'b0, 1'b0);
        send_column(CW'(2), 1'b1, 1'b0, 1'b0);
        send_column(CW'(1), 1'b1, 1'b1, 1'b1);
        send_column(CW'(3), 1'b1, 1'b0, 1'b0);
        send_column(CW'(GRID / 2 - 1), 1'b0, 1'b1, 1'b0);

        // center growth only at the middle column
        set_mode(1'b0, 1'b1);
        send_column(CW'(GRID / 2), 1'b0, 1'b0, 1'b1);
        send_column(CW'(300), 1'b0, 1'b0, 1'b1);
        send_column(CW'(GRID / 2), 1'b1, 1'b0, 1'b1);

        // edge copy, including items that move nothing
        set_mode(1'b1, 1'b1);
        send_column(CW'(1), 1'b0, 1'b1, 1'b0);
        send_column(CW'(100), 1'b0, 1'b0, 1'b0);
        send_column(CW'(GRID - 2), 1'b1, 1'b0, 1'b0);
        send_column(CW'(GRID - 3), 1'b0, 1'b1, 1'b1);

        set_mode(1'b0, 1'b0);
        random_phase(45);

        // up to five words per item and a long pixel stall fill the block up
        set_mode(1'b1, 1'b1);
        squeeze_req = 1'b1;
        random_phase(45);

        set_mode(1'b0, 1'b1);
        no_gaps = 1'b1;
        random_phase(45);
        no_gaps = 1'b0;

        set_mode(1'b1, 1'b0);
        random_phase(45);
        settle();

        if (mismatches == 0)
            $display("[growth_interface_column_update] OK");
        else
            $display("[growth_interface_column_update] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gicu_pkg.sv
rtl/gicu_in_if.sv
rtl/gicu_out_if.sv
rtl/gicu_cfg_if.sv
rtl/gicu_ram.sv
rtl/gicu_update.sv
rtl/gicu_emit.sv
rtl/growth_interface_column_update.sv
rtl/gicu_chk.sv
test/gicu_checker.sv
test/tb_growth_interface_column_update.sv
